// ===== rtl/cla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_pkg
// shared types, sizes and codes of the command line assembler
// ----------------------------------------------------------------------------
package cla_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int ADDR_W    = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int IDX_W     = 6;
	localparam int LC_W      = 7;
	localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int EXT_W     = (CNT_W > LC_W) ? CNT_W : LC_W;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_FLUSH = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] CFG_EOL_A = 2'd0;
	localparam logic [1:0] CFG_EOL_B = 2'd1;
	localparam logic [1:0] CFG_SKIP  = 2'd2;
	localparam logic [1:0] CFG_TERM  = 2'd3;

	localparam logic [7:0] RST_EOL_A = 8'd10;
	localparam logic [7:0] RST_EOL_B = 8'd13;
	localparam logic [7:0] RST_SKIP  = 8'd32;
	localparam logic [7:0] RST_TERM  = 8'd0;

	typedef struct packed {
		logic [7:0] eol_a;
		logic [7:0] eol_b;
		logic [7:0] skip;
		logic [7:0] term;
	} cla_cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             complete;
		logic             ovf;
	} cla_state_t;

	typedef struct packed {
		cla_state_t        next;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              rd_en;
		logic [ADDR_W-1:0] raddr;
	} cla_upd_t;

endpackage

// ===== rtl/cla_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_core
// next-state logic for one beat: line state update, store write, read enable
// ----------------------------------------------------------------------------
module cla_core (
	input  cla_pkg::cla_cfg_t   cfg,
	input  cla_pkg::cla_state_t cur,
	input  logic [1:0]          op,
	input  logic [7:0]          char_byte,
	input  logic [5:0]          read_index,
	output cla_pkg::cla_upd_t   upd
);

	logic                      full;
	logic                      empty;
	logic                      eol;
	logic                      last_slot;
	logic [cla_pkg::CMP_W-1:0] idx_ext;
	logic [cla_pkg::CMP_W-1:0] cnt_ext;

	assign full      = cur.count == cla_pkg::CNT_W'(cla_pkg::BUF_DEPTH);
	assign empty     = cur.count == '0;
	assign last_slot = cur.count == cla_pkg::CNT_W'(cla_pkg::BUF_DEPTH - 1);
	assign eol       = (char_byte == cfg.eol_a) || (char_byte == cfg.eol_b);
	assign idx_ext   = cla_pkg::CMP_W'(read_index);
	assign cnt_ext   = cla_pkg::CMP_W'(cur.count);

	always_comb begin
		upd       = '0;
		upd.next  = cur;
		upd.waddr = cur.count[cla_pkg::ADDR_W-1:0];
		upd.wdata = char_byte;
		upd.raddr = idx_ext[cla_pkg::ADDR_W-1:0];
		case (op)
			cla_pkg::OP_ADD: begin
				if (!full && !cur.ovf && !(empty && (eol || char_byte == cfg.skip))) begin
					if (!empty && eol) begin
						upd.we            = 1'b1;
						upd.wdata         = cfg.term;
						upd.next.count    = cur.count + 1'b1;
						upd.next.complete = 1'b1;
					end else if (last_slot) begin
						upd.next.ovf      = 1'b1;
						upd.next.count    = '0;
						upd.next.complete = 1'b0;
					end else begin
						upd.we         = 1'b1;
						upd.next.count = cur.count + 1'b1;
					end
				end else if (cur.ovf && eol) begin
					upd.next.ovf      = 1'b0;
					upd.next.count    = '0;
					upd.next.complete = 1'b0;
				end
			end
			cla_pkg::OP_FLUSH: begin
				upd.next.count    = '0;
				upd.next.complete = 1'b0;
			end
			cla_pkg::OP_READ: begin
				upd.rd_en = idx_ext < cnt_ext;
			end
			default: begin
				upd.next = cur;
			end
		endcase
	end

endmodule

// ===== rtl/command_line_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_assembler
// collects received characters into one terminated command line
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one beat per operation: tuser holds the op code (add a
//   character, flush, read a byte), tdata the character and the read index
//   m_axis returns one status beat per input beat: read byte, line count,
//   complete, overflow and full flags, in input order
//   cfg writes the end-of-line, skip and terminator characters; write it
//   only while no beat is in flight
// timing:
//   each accepted beat passes the input register, then the result register,
//   and updates the line in one pass; one beat per cycle with m_axis_tready high
// reset:
//   arst_n empties the line, clears both flags and restores the default
//   characters; the line store itself is not cleared
// back-pressure:
//   when m_axis_tready is low the result beat holds; an input beat is taken
//   only into an empty input register, and then s_axis_tready drops
// ----------------------------------------------------------------------------
module command_line_assembler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // char_byte[7:0], read_index[13:8], zero[15:14]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_byte[7:0], line_count[14:8], line_complete[15], overflow[16],
	// buffer_full[17], zero[23:18]
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cla_pkg::cla_cfg_t   cfg_q;
	cla_pkg::cla_state_t state_q;
	cla_pkg::cla_upd_t   upd;

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] char_s1;
	logic [5:0] idx_s1;
	logic       adv_s1;
	logic       accept_in;

	logic                      valid_s2;
	logic                      rd_en_s2;
	logic [7:0]                rdata_s2;
	logic [cla_pkg::CNT_W-1:0] count_s2;
	logic                      complete_s2;
	logic                      ovf_s2;
	logic [cla_pkg::EXT_W-1:0] count_ext;
	logic                      full_out;
	logic [7:0]                read_byte;

	logic [7:0] mem [cla_pkg::BUF_DEPTH];

	assign cfg_ready     = 1'b1;
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept_in     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eol_a <= cla_pkg::RST_EOL_A;
			cfg_q.eol_b <= cla_pkg::RST_EOL_B;
			cfg_q.skip  <= cla_pkg::RST_SKIP;
			cfg_q.term  <= cla_pkg::RST_TERM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cla_pkg::CFG_EOL_A: cfg_q.eol_a <= cfg_data;
				cla_pkg::CFG_EOL_B: cfg_q.eol_b <= cfg_data;
				cla_pkg::CFG_SKIP:  cfg_q.skip  <= cfg_data;
				cla_pkg::CFG_TERM:  cfg_q.term  <= cfg_data;
				default:            cfg_q       <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_s1   <= s_axis_tuser;
			char_s1 <= s_axis_tdata[7:0];
			idx_s1  <= s_axis_tdata[13:8];
		end
	end

	cla_core u_core (
		.cfg        (cfg_q),
		.cur        (state_q),
		.op         (op_s1),
		.char_byte  (char_s1),
		.read_index (idx_s1),
		.upd        (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= upd.next;
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (adv_s1 && upd.we) begin
			mem[upd.waddr] <= upd.wdata;
		end
		if (adv_s1) begin
			rdata_s2 <= mem[upd.raddr];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rd_en_s2    <= upd.rd_en;
			count_s2    <= upd.next.count;
			complete_s2 <= upd.next.complete;
			ovf_s2      <= upd.next.ovf;
		end
	end

	assign count_ext = cla_pkg::EXT_W'(count_s2);
	assign full_out  = count_s2 == cla_pkg::CNT_W'(cla_pkg::BUF_DEPTH);
	assign read_byte = rd_en_s2 ? rdata_s2 : 8'd0;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, full_out, ovf_s2, complete_s2,
		count_ext[cla_pkg::LC_W-1:0], read_byte};

endmodule

// ===== rtl/cla_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cla_checker
// port-level checks of the command line assembler, bound to the top level
// ----------------------------------------------------------------------------
module cla_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	// overflow discards the line, so no completed line can coexist with it
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[15] && m_axis_tdata[16]))
		else $error("line complete while in overflow");

	// overflow always reports an empty line
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[16]) |-> (m_axis_tdata[14:8] == 7'd0))
		else $error("overflow with a nonzero line count");

	// full flag agrees with the reported count
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[17]) |->
			(m_axis_tdata[14:8] == 7'(cla_pkg::BUF_DEPTH)))
		else $error("buffer full with a wrong line count");

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result beat changed while stalled");

endmodule

bind command_line_assembler cla_checker u_cla_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
